// ----- rtl/vpci_pkg.sv -----
// Shared types and constants of the vertex pair cycle intersection filter.
`default_nettype none

package vpci_pkg;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W     = 2;
    localparam int LEN_W     = 5;
    localparam int MASK_W    = 26;
    localparam int IDX_W     = 9;
    localparam int CNT_OUT_W = 9;
    localparam int TABLE_W   = 42;
    localparam int SLOT_W    = 4;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    localparam logic [LEN_W-1:0]   MIN_CYCLE_LENGTH = 5'd3;
    localparam logic [TABLE_W-1:0] TABLE_RESET      = 42'd3654480253652;

    // Command codes carried in s_tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_RESTORE = 2'd0,
        CMD_APPLY   = 2'd1,
        CMD_READ    = 2'd2
    } cmd_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic       restore;
        logic       apply;
        logic       shift;
        logic [2:0] allow;
    } cell_ctrl_t;

    // Control of the scan unit at the head of the chain.
    typedef struct packed {
        logic start;
        logic step;
        logic is_read;
    } scan_ctrl_t;

    // Status returned by the scan unit.
    typedef struct packed {
        logic last;
        logic is_read;
        logic found;
    } scan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/vertex_pair_cycle_intersection_filter.sv -----
// Top level of the vertex pair cycle intersection filter: ring of cells and sequencer.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tuser: cmd; s_tdata: length, mask, index
//  m_       out        m_tvalid / m_tready  m_tdata: count, empty, read mask, read valid
//  cfg_     in         cfg_we               cfg_wdata: allowed table
//
// Restore, unknown commands, an apply with a length out of range and a read past the
// end finish in the cycle of acceptance. A valid apply or read runs the scan and finish
// states: the flags rotate once around the cell ring past the scan unit at its head.
// Reset (synchronous, active low) keeps every pair and loads the default table.
// A result waiting for m_tready holds s_tready low; it may leave in the accepting cycle.
`default_nettype none

module vertex_pair_cycle_intersection_filter #(
    parameter int VERTEX_COUNT     = 26,
    parameter int MAX_CYCLE_LENGTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input transaction.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // cycle_length[4:0], cycle_mask[30:5], read_index[39:31]
    input  wire logic [vpci_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  wire logic [vpci_pkg::CMD_W-1:0]      s_tuser,
    // Result transaction.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // survivor_count[8:0], set_empty[9], read_mask[35:10], read_valid[36]
    output logic [vpci_pkg::M_DATA_W-1:0]        m_tdata,
    // Configuration write.
    input  wire logic                            cfg_we,
    input  wire logic [vpci_pkg::TABLE_W-1:0]    cfg_wdata
);
    import vpci_pkg::*;

    localparam int PAIR_COUNT = (VERTEX_COUNT * (VERTEX_COUNT - 1)) / 2;
    localparam int CNT_W      = $clog2(PAIR_COUNT + 1);

    state_t              state_reg, state_next;
    logic [TABLE_W-1:0]  table_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic [CNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic [MASK_W-1:0]   out_mask_reg, out_mask_next;
    logic                out_rvalid_reg, out_rvalid_next;

    logic [LEN_W-1:0]    in_len;
    logic [MASK_W-1:0]   in_mask;
    logic [IDX_W-1:0]    in_index;
    logic                accept;
    logic                slot_free;
    logic                len_ok;
    logic                index_ok;
    logic                start_apply;
    logic                start_read;
    logic                load_finish;
    logic [SLOT_W-1:0]   slot;
    logic [2:0]          allow;

    cell_ctrl_t          cell_ctrl;
    scan_ctrl_t          scan_ctrl;
    scan_stat_t          scan_stat;
    logic [CNT_W-1:0]    scan_count;
    logic [MASK_W-1:0]   scan_mask;
    logic [PAIR_COUNT-1:0] flags;

    assign in_len   = s_tdata[LEN_W-1:0];
    assign in_mask  = s_tdata[LEN_W +: MASK_W];
    assign in_index = s_tdata[LEN_W + MASK_W +: IDX_W];

    assign slot_free = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // Decode of the command and its range checks.
    assign len_ok   = (in_len >= MIN_CYCLE_LENGTH) && (in_len <= LEN_W'(MAX_CYCLE_LENGTH));
    assign index_ok = in_index < IDX_W'(count_reg);
    assign slot     = SLOT_W'(in_len - MIN_CYCLE_LENGTH);
    assign allow    = 3'(table_reg >> (6'(slot) * 6'd3));

    always_comb begin
        start_apply = 1'b0;
        start_read  = 1'b0;
        case (s_tuser)
            CMD_APPLY: start_apply = accept && len_ok;
            CMD_READ:  start_read  = accept && index_ok;
            default:   ;
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_apply || start_read) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_stat.last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready          = 1'b0;
        load_finish       = 1'b0;
        cell_ctrl.restore = 1'b0;
        cell_ctrl.apply   = 1'b0;
        cell_ctrl.shift   = 1'b0;
        cell_ctrl.allow   = allow;
        scan_ctrl.start   = 1'b0;
        scan_ctrl.step    = 1'b0;
        scan_ctrl.is_read = start_read;
        case (state_reg)
            ST_IDLE: begin
                s_tready          = slot_free;
                cell_ctrl.restore = accept && (s_tuser == CMD_RESTORE);
                cell_ctrl.apply   = start_apply;
                scan_ctrl.start   = start_apply || start_read;
            end
            ST_SCAN: begin
                cell_ctrl.shift = 1'b1;
                scan_ctrl.step  = 1'b1;
            end
            ST_FINISH: begin
                load_finish = slot_free;
            end
            default: ;
        endcase
    end

    // Ring of cells in ascending pair order; each takes its right neighbor's flag.
    generate
        for (genvar a = 0; a < VERTEX_COUNT - 1; a++) begin : g_row
            for (genvar b = a + 1; b < VERTEX_COUNT; b++) begin : g_col
                localparam int K = a * VERTEX_COUNT - (a * (a + 1)) / 2 + (b - a - 1);
                vpci_cell #(
                    .VERT_A (a),
                    .VERT_B (b)
                ) u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (cell_ctrl),
                    .cycle_mask (in_mask),
                    .flag_in    (flags[(K + 1) % PAIR_COUNT]),
                    .flag_out   (flags[K])
                );
            end
        end
    endgenerate

    vpci_scan #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .PAIR_COUNT   (PAIR_COUNT),
        .CNT_W        (CNT_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (scan_ctrl),
        .read_index (in_index),
        .head_flag  (flags[0]),
        .stat       (scan_stat),
        .count      (scan_count),
        .read_mask  (scan_mask)
    );

    // Survivor count: full on restore, recounted at the end of an apply scan.
    always_comb begin
        count_next = count_reg;
        if (cell_ctrl.restore) begin
            count_next = CNT_W'(PAIR_COUNT);
        end else if (scan_stat.last && !scan_stat.is_read) begin
            count_next = scan_count;
        end
    end

    // Result register: loaded at acceptance for quick commands, else after the scan.
    always_comb begin
        m_valid_next    = m_valid_reg && !m_tready;
        out_count_next  = out_count_reg;
        out_mask_next   = out_mask_reg;
        out_rvalid_next = out_rvalid_reg;
        if (accept && !start_apply && !start_read) begin
            m_valid_next    = 1'b1;
            out_count_next  = (s_tuser == CMD_RESTORE) ? CNT_OUT_W'(PAIR_COUNT)
                                                       : CNT_OUT_W'(count_reg);
            out_mask_next   = '0;
            out_rvalid_next = 1'b0;
        end else if (load_finish) begin
            m_valid_next    = 1'b1;
            out_count_next  = CNT_OUT_W'(count_reg);
            out_mask_next   = scan_mask;
            out_rvalid_next = scan_stat.found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            table_reg   <= TABLE_RESET;
            count_reg   <= CNT_W'(PAIR_COUNT);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                table_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_count_reg  <= out_count_next;
        out_mask_reg   <= out_mask_next;
        out_rvalid_reg <= out_rvalid_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_rvalid_reg, out_mask_reg,
                       (out_count_reg == '0), out_count_reg};

`ifndef SYNTHESIS
    // The survivor count never exceeds the number of pairs.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PAIR_COUNT))
        else $error("survivor count above pair count");

    // The finish state is entered only from a scan.
    a_finish_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> ($past(state_reg) == ST_SCAN ||
                                      $past(state_reg) == ST_FINISH))
        else $error("finish state without a scan");

    // A failed read carries no pair, a found one carries at most two vertices.
    a_read_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((out_rvalid_reg || out_mask_reg == '0) &&
                         $countones(out_mask_reg) <= 2))
        else $error("read mask inconsistent with read valid");

    // No transaction is taken while the ring is rotating.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !accept && !cell_ctrl.restore && !cell_ctrl.apply)
        else $error("transaction taken during a scan");
`endif

endmodule

`default_nettype wire

// ----- rtl/vpci_cell.sv -----
// One candidate cell: holds the keep flag of one vertex pair.
`default_nettype none

module vpci_cell #(
    parameter int VERT_A = 0,
    parameter int VERT_B = 1
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire vpci_pkg::cell_ctrl_t      ctrl,
    input  wire logic [vpci_pkg::MASK_W-1:0] cycle_mask,
    input  wire logic                      flag_in,
    output logic                           flag_out
);
    import vpci_pkg::*;

    logic flag_reg;
    logic flag_next;
    logic hit_a;
    logic hit_b;
    logic kept;

    // Vertices beyond the mask field never lie on the cycle.
    generate
        if (VERT_A < MASK_W) begin : g_hit_a
            assign hit_a = cycle_mask[VERT_A];
        end else begin : g_no_a
            assign hit_a = 1'b0;
        end
        if (VERT_B < MASK_W) begin : g_hit_b
            assign hit_b = cycle_mask[VERT_B];
        end else begin : g_no_b
            assign hit_b = 1'b0;
        end
    endgenerate

    // Select the allow bit for an intersection of zero, one or two vertices.
    always_comb begin
        if (hit_a && hit_b) begin
            kept = ctrl.allow[2];
        end else if (hit_a || hit_b) begin
            kept = ctrl.allow[1];
        end else begin
            kept = ctrl.allow[0];
        end
    end

    // Restore, filter in place, or pass the flag along the ring.
    always_comb begin
        flag_next = flag_reg;
        if (ctrl.restore) begin
            flag_next = 1'b1;
        end else if (ctrl.apply) begin
            flag_next = flag_reg & kept;
        end else if (ctrl.shift) begin
            flag_next = flag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b1;
        end else begin
            flag_reg <= flag_next;
        end
    end

    assign flag_out = flag_reg;

endmodule

`default_nettype wire

// ----- rtl/vpci_scan.sv -----
// Scan unit at the head of the chain: counts survivors and picks the k-th one.
`default_nettype none

module vpci_scan #(
    parameter int VERTEX_COUNT = 26,
    parameter int PAIR_COUNT   = 325,
    parameter int CNT_W        = 9
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire vpci_pkg::scan_ctrl_t       ctrl,
    input  wire logic [vpci_pkg::IDX_W-1:0] read_index,
    input  wire logic                       head_flag,
    output vpci_pkg::scan_stat_t            stat,
    output logic [CNT_W-1:0]                count,
    output logic [vpci_pkg::MASK_W-1:0]     read_mask
);
    import vpci_pkg::*;

    localparam int VW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int PTR_W = $clog2(PAIR_COUNT);

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [VW-1:0]     a_reg, a_next;
    logic [VW-1:0]     b_reg, b_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              found_reg, found_next;
    logic              read_reg, read_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [MASK_W-1:0] pair_mask;
    logic              hit;

    // Mask of the pair now leaving the head cell, cut to the field width.
    always_comb begin
        for (int v = 0; v < MASK_W; v++) begin
            pair_mask[v] = (int'(a_reg) == v) || (int'(b_reg) == v);
        end
    end

    assign hit = read_reg && head_flag && !found_reg && (IDX_W'(seen_reg) == k_reg);

    // Walk the pairs in ascending order while the ring rotates once.
    always_comb begin
        ptr_next   = ptr_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        seen_next  = seen_reg;
        k_next     = k_reg;
        found_next = found_reg;
        read_next  = read_reg;
        mask_next  = mask_reg;
        if (ctrl.start) begin
            ptr_next   = '0;
            a_next     = '0;
            b_next     = VW'(1);
            seen_next  = '0;
            k_next     = read_index;
            found_next = 1'b0;
            read_next  = ctrl.is_read;
            mask_next  = '0;
        end else if (ctrl.step) begin
            ptr_next  = ptr_reg + PTR_W'(1);
            seen_next = seen_reg + CNT_W'(head_flag);
            if (b_reg == VW'(VERTEX_COUNT - 1)) begin
                a_next = a_reg + VW'(1);
                b_next = a_reg + VW'(2);
            end else begin
                b_next = b_reg + VW'(1);
            end
            if (hit) begin
                found_next = 1'b1;
                mask_next  = pair_mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            found_reg <= 1'b0;
            read_reg  <= 1'b0;
            mask_reg  <= '0;
        end else begin
            ptr_reg   <= ptr_next;
            found_reg <= found_next;
            read_reg  <= read_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        seen_reg <= seen_next;
        k_reg    <= k_next;
    end

    assign stat.last    = ctrl.step && (ptr_reg == PTR_W'(PAIR_COUNT - 1));
    assign stat.is_read = read_reg;
    assign stat.found   = found_reg;
    assign count        = seen_reg + CNT_W'(head_flag);
    assign read_mask    = mask_reg;

endmodule

`default_nettype wire

// ----- test/vpci_result_checker.sv -----
// Checker of the vertex pair filter: tracks the candidate set and compares every result.
module vpci_result_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [vpci_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [vpci_pkg::CMD_W-1:0]      s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [vpci_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [vpci_pkg::TABLE_W-1:0]    cfg_wdata,
    output int                                   mismatch_count,
    output int                                   waiting_results,
    output int                                   results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import vpci_pkg::*;

    localparam int VERTICES  = 26;
    localparam int PAIRS     = VERTICES * (VERTICES - 1) / 2;
    localparam int MAX_LEN   = 16;
    localparam int SHOW_LIMIT = 10;

    // One result transaction, laid out as in m_tdata from bit 36 down.
    typedef struct packed {
        logic                read_valid;
        logic [MASK_W-1:0]   read_mask;
        logic                set_empty;
        logic [CNT_OUT_W-1:0] survivor_count;
    } filter_result_t;

    // Candidate pairs in ascending order and the predicted state of the block.
    logic [MASK_W-1:0]  pair_of [PAIRS];
    logic [PAIRS-1:0]   kept;
    int                 kept_total;
    logic [TABLE_W-1:0] allow_table;
    filter_result_t     expected_results [$];

    // Pair masks: a runs upward, and for each a, b runs upward.
    initial begin : pair_list
        int k;
        k = 0;
        for (int a = 0; a < VERTICES - 1; a++) begin
            for (int b = a + 1; b < VERTICES; b++) begin
                pair_of[k] = (MASK_W'(1) << a) | (MASK_W'(1) << b);
                k++;
            end
        end
    end

    function automatic void restore_pairs();
        kept       = '1;
        kept_total = PAIRS;
    endfunction

    // Update the candidate set for one input transaction and return its result.
    function automatic filter_result_t filter_step(logic [CMD_W-1:0] cmd,
                                                   logic [S_DATA_W-1:0] word);
        logic [LEN_W-1:0]  len;
        logic [MASK_W-1:0] cmask;
        logic [IDX_W-1:0]  idx;
        logic [2:0]        allow;
        int                seen;
        filter_result_t    r;
        len   = word[4:0];
        cmask = word[30:5];
        idx   = word[39:31];
        r     = '0;
        case (cmd)
            CMD_RESTORE: begin
                restore_pairs();
            end
            CMD_APPLY: begin
                // Lengths outside 3..16 leave the set as it is.
                if (len >= MIN_CYCLE_LENGTH && len <= MAX_LEN) begin
                    allow = allow_table[3 * (len - MIN_CYCLE_LENGTH) +: 3];
                    for (int i = 0; i < PAIRS; i++) begin
                        if (kept[i] && !allow[$countones(pair_of[i] & cmask)]) begin
                            kept[i] = 1'b0;
                        end
                    end
                    kept_total = $countones(kept);
                end
            end
            CMD_READ: begin
                // A position past the last survivor reads as not valid.
                if (idx < kept_total) begin
                    seen = 0;
                    for (int i = 0; i < PAIRS; i++) begin
                        if (kept[i]) begin
                            if (seen == idx) begin
                                r.read_mask  = pair_of[i];
                                r.read_valid = 1'b1;
                                break;
                            end
                            seen++;
                        end
                    end
                end
            end
            default: begin
                // Unknown command: nothing changes.
            end
        endcase
        r.survivor_count = CNT_OUT_W'(kept_total);
        r.set_empty      = (kept_total == 0);
        return r;
    endfunction

    // Compare results first, then record what the accepted input will produce.
    always @(posedge aclk) begin : watch
        filter_result_t got;
        filter_result_t want;
        if (!aresetn) begin
            restore_pairs();
            allow_table = TABLE_RESET;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[36:0];
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("result %0d arrived with none expected:", results_seen);
                        $display("    count %0d empty %0b mask %h valid %0b",
                                 got.survivor_count, got.set_empty,
                                 got.read_mask, got.read_valid);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.survivor_count !== want.survivor_count ||
                        got.set_empty !== want.set_empty ||
                        got.read_mask !== want.read_mask ||
                        got.read_valid !== want.read_valid) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_LIMIT) begin
                            $display("result %0d mismatch:", results_seen);
                            $display("    expected count %0d empty %0b mask %h valid %0b",
                                     want.survivor_count, want.set_empty,
                                     want.read_mask, want.read_valid);
                            $display("    actual count %0d empty %0b mask %h valid %0b",
                                     got.survivor_count, got.set_empty,
                                     got.read_mask, got.read_valid);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(),
                                        filter_step(s_tuser, s_tdata));
            end
            if (cfg_we) begin
                allow_table = cfg_wdata;
            end
        end
        waiting_results = expected_results.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top of the vertex pair filter: clock, reset, stimulus, sink and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vpci_pkg::*;

    localparam int PAIR_COUNT  = 325;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 115;
    localparam int LONG_HOLD   = 4000;
    localparam int SETTLE      = 8;
    localparam logic [CMD_W-1:0]   CMD_UNDEFINED = 2'd3;
    localparam logic [MASK_W-1:0]  ALL_VERTICES  = '1;
    localparam logic [TABLE_W-1:0] TABLE_NONE    = '0;
    localparam logic [TABLE_W-1:0] TABLE_ALL     = '1;
    localparam logic [TABLE_W-1:0] TABLE_ONLY_0  = 42'h092_4924_9249;
    localparam logic [TABLE_W-1:0] TABLE_ONLY_1  = 42'h124_9249_2492;
    localparam logic [TABLE_W-1:0] TABLE_ONLY_2  = 42'h249_2492_4924;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]     s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [TABLE_W-1:0]   cfg_wdata = '0;

    int mismatch_count;
    int waiting_results;
    int results_seen;

    // Shared between the sender and the sink; the sink reads them at the falling edge.
    bit calm            = 1'b0;
    int holds_requested = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    vertex_pair_cycle_intersection_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    vpci_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .waiting_results (waiting_results),
        .results_seen    (results_seen)
    );

    // Idle stretch: mostly short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Offer one input transaction and return once it has been accepted.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
                             input logic [MASK_W-1:0] cmask, input logic [IDX_W-1:0] idx);
        bit taken;
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= {idx, cmask, len};
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Mostly restore, apply and read sequences; some noise commands and bad lengths.
    task automatic send_random_item();
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  len;
        logic [MASK_W-1:0] cmask;
        logic [IDX_W-1:0]  idx;
        int pick;
        int want;
        cmd   = CMD_W'($urandom);
        len   = LEN_W'($urandom);
        cmask = MASK_W'($urandom);
        idx   = IDX_W'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 8) begin
            cmd = CMD_RESTORE;
        end else if (pick < 50) begin
            cmd = CMD_APPLY;
            if ($urandom_range(0, 9) != 0) len = LEN_W'($urandom_range(3, 16));
            case ($urandom_range(0, 2))
                0: cmask = MASK_W'($urandom);
                1: cmask = MASK_W'($urandom & $urandom & $urandom);
                default: begin
                    // A cycle through exactly len vertices, or through all MASK_W if len is larger.
                    want  = (int'(len) > MASK_W) ? MASK_W : int'(len);
                    cmask = '0;
                    while ($countones(cmask) < want) begin
                        cmask[$urandom_range(0, MASK_W - 1)] = 1'b1;
                    end
                end
            endcase
        end else if (pick < 94) begin
            cmd  = CMD_READ;
            pick = $urandom_range(0, 99);
            if (pick < 40)      idx = IDX_W'($urandom_range(0, 15));
            else if (pick < 65) idx = IDX_W'($urandom_range(0, 63));
            else if (pick < 90) idx = IDX_W'($urandom_range(0, PAIR_COUNT - 1));
        end else begin
            cmd = CMD_UNDEFINED;
        end
        send_item(cmd, len, cmask, idx);
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (waiting_results != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_table(input logic [TABLE_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Result sink: random ready pattern, calm stretches and the requested long holds.
    initial begin : result_sink
        int  span;
        bit  level;
        int  holds_done;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (holds_done < holds_requested) begin
                holds_done++;
                span  = LONG_HOLD;
                level = 1'b0;
            end else if (calm) begin
                span  = 1;
                level = 1'b1;
            end else if ($urandom_range(0, 1) != 0) begin
                span  = $urandom_range(1, 12);
                level = 1'b1;
            end else begin
                span  = idle_length();
                level = 1'b0;
            end
            @(posedge aclk);
            m_tready <= level;
            repeat (span - 1) @(posedge aclk);
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        logic [TABLE_W-1:0] settings [PHASES];
        settings[0] = TABLE_NONE;
        settings[1] = TABLE_ALL;
        settings[2] = TABLE_ONLY_2;
        settings[3] = TABLE_W'({$urandom, $urandom});
        settings[4] = TABLE_RESET;
        settings[5] = TABLE_ONLY_1;
        settings[6] = TABLE_ONLY_0;
        settings[7] = TABLE_W'({$urandom, $urandom});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the table left at its reset value.
        send_item(CMD_READ, '0, '0, 9'd0);
        send_item(CMD_READ, '0, '0, 9'd324);
        send_item(CMD_READ, '0, '0, 9'd325);
        send_item(CMD_READ, '0, '0, 9'd511);
        send_item(CMD_UNDEFINED, 5'd31, ALL_VERTICES, 9'd511);
        // Lengths out of range leave the set unchanged.
        send_item(CMD_APPLY, 5'd0, ALL_VERTICES, '0);
        send_item(CMD_APPLY, 5'd2, ALL_VERTICES, '0);
        send_item(CMD_APPLY, 5'd17, ALL_VERTICES, '0);
        send_item(CMD_APPLY, 5'd31, ALL_VERTICES, 9'd511);
        send_item(CMD_READ, '0, '0, 9'd324);
        send_item(CMD_APPLY, 5'd3, '0, '0);
        send_item(CMD_READ, '0, '0, 9'd0);
        send_item(CMD_APPLY, 5'd16, ALL_VERTICES, '0);
        send_item(CMD_READ, '0, '0, 9'd0);
        send_item(CMD_RESTORE, 5'd31, ALL_VERTICES, 9'd511);
        send_item(CMD_APPLY, 5'd4, 26'h155_5555, '0);
        send_item(CMD_APPLY, 5'd9, 26'h2AA_AAAA, '0);
        send_item(CMD_READ, '0, '0, 9'd0);
        send_item(CMD_READ, '0, '0, 9'd511);
        send_item(CMD_RESTORE, '0, '0, '0);
        send_item(CMD_READ, '0, '0, 9'd324);
        send_item(CMD_APPLY, 5'd7, 26'h000_000F, '0);
        send_item(CMD_READ, '0, '0, 9'd0);
        wait_for_results();

        // Random phases, each under its own table setting.
        for (int p = 0; p < PHASES; p++) begin
            write_table(settings[p]);
            calm = ($urandom_range(0, 3) == 0);
            if (p == 1 || p == 5) holds_requested++;
            repeat (PHASE_ITEMS) send_random_item();
            wait_for_results();
        end
        calm = 1'b0;

        repeat (PAIR_COUNT + 20) @(posedge aclk);
        if (mismatch_count == 0 && waiting_results == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin : watchdog
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
